>>> hdl/mct_pkg.sv
`default_nettype none

package mct_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned CH_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TPM_W    = 16;

  localparam logic [31:0] WRAP_RST      = 32'hFFFF_FFFF;
  localparam logic [31:0] LARGEST_RST   = 32'h0000_FFFF;
  localparam logic [15:0] TPM_RST       = 16'd500;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_ARM_ABS   = 3'd1,
    OP_ARM_DELAY = 3'd2,
    OP_DISABLE   = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_REPEAT    = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP      = 2'd0,
    REG_TIMER_EN  = 2'd1,
    REG_LARGEST   = 2'd2,
    REG_TPM       = 2'd3
  } cfg_reg_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_COUNT = 8'b0000_0010,
    S_MATCH = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_ARM   = 8'b0010_0000,
    S_MISC  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic count;
    logic match;
    logic mul;
    logic sum;
    logic arm;
    logic misc;
    logic load_out;
  } mct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic timer_en;
  } mct_status_t;

endpackage

`default_nettype wire

>>> hdl/mct_if.sv
`default_nettype none

interface mct_in_if import mct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CH_W-1:0]   channel;
  logic [VALUE_W-1:0] value;
  logic [MASK_W-1:0] clear_mask;
  logic              repeat_on;

  modport source (output valid, operation, channel, value, clear_mask, repeat_on,
                  input ready);
  modport sink   (input valid, operation, channel, value, clear_mask, repeat_on,
                  output ready);
endinterface

interface mct_out_if import mct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [31:0]       counter_value;
  logic [MASK_W-1:0] pending_bits;
  logic [MASK_W-1:0] fired_bits;
  logic              irq;

  modport source (output valid, counter_value, pending_bits, fired_bits, irq,
                  input ready);
  modport sink   (input valid, counter_value, pending_bits, fired_bits, irq,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/mct_ctrl.sv
`default_nettype none

module mct_ctrl import mct_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire  [OP_W-1:0]  in_op_i,
  output logic             in_ready_o,
  input  wire              out_ready_i,
  output logic             out_valid_o,
  input  mct_status_t      status_i,
  output mct_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          case (op_e'(in_op_i))
            OP_TICK:      state_d = status_i.timer_en ? S_COUNT : S_DONE;
            OP_ARM_ABS:   state_d = S_ARM;
            OP_ARM_DELAY: state_d = S_MUL;
            OP_DISABLE:   state_d = S_MISC;
            OP_CLEAR:     state_d = S_MISC;
            OP_REPEAT:    state_d = S_MISC;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = S_MATCH;
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_ARM;
      end
      S_ARM: begin
        cmd_o.arm = 1'b1;
        state_d   = S_DONE;
      end
      S_MISC: begin
        cmd_o.misc = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // hand result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/mct_datapath.sv
`default_nettype none

module mct_datapath import mct_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  input  wire  [OP_W-1:0]       in_op_i,
  input  wire  [CH_W-1:0]       in_ch_i,
  input  wire  [VALUE_W-1:0]    in_value_i,
  input  wire  [MASK_W-1:0]     in_clr_i,
  input  wire                   in_rep_i,
  input  mct_cmd_t              cmd_i,
  output mct_status_t           status_o,
  output logic [31:0]           counter_value_o,
  output logic [MASK_W-1:0]     pending_bits_o,
  output logic [MASK_W-1:0]     fired_bits_o,
  output logic                  irq_o
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [NUM_CHANNELS-1:0] chv_t;

  // configuration
  cnt_t        max_q, max_d;
  logic        ten_q, ten_d;
  logic [31:0] lint_q, lint_d;
  logic [TPM_W-1:0] tpm_q, tpm_d;

  // timer state
  cnt_t        count_q, count_d;
  cnt_t        cmp_q [NUM_CHANNELS];
  cnt_t        cmp_d [NUM_CHANNELS];
  logic [31:0] per_q [NUM_CHANNELS];
  logic [31:0] per_d [NUM_CHANNELS];
  chv_t        en_q, en_d, pend_q, pend_d, rep_q, rep_d, fired_q, fired_d;

  // request and work registers
  op_e         op_q;
  logic [CH_W-1:0]   ch_q;
  logic [VALUE_W-1:0] val_q;
  logic [MASK_W-1:0] clr_q;
  logic        rep_on_q;
  logic [31:0] prod_q, target_q;

  chv_t        sel;
  cnt_t        arm_t;
  logic        arm_late;
  logic [15:0] clr_ext;
  logic [31:0] pend_ext, fired_ext;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sel[i] = (32'(ch_q) == 32'(i));
    end
    arm_t    = target_q[COUNT_WIDTH-1:0] & max_q;
    arm_late = (32'(arm_t) - 32'(count_q)) >= lint_q;
    clr_ext  = 16'(clr_q);
    pend_ext = 32'(pend_q);
    fired_ext = 32'(fired_q);
  end

  always_comb begin
    max_d   = max_q;
    ten_d   = ten_q;
    lint_d  = lint_q;
    tpm_d   = tpm_q;
    count_d = count_q;
    cmp_d   = cmp_q;
    per_d   = per_q;
    en_d    = en_q;
    pend_d  = pend_q;
    rep_d   = rep_q;
    fired_d = fired_q;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WRAP:      max_d  = cfg_data_i[COUNT_WIDTH-1:0];
        REG_TIMER_EN:  ten_d  = cfg_data_i[0];
        REG_LARGEST:   lint_d = cfg_data_i;
        REG_TPM:       tpm_d  = cfg_data_i[TPM_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.load_item) begin
      fired_d = '0;
    end

    if (cmd_i.count) begin
      count_d = (count_q >= max_q) ? '0 : count_q + cnt_t'(1);
    end

    // count_q already holds the advanced value here
    if (cmd_i.match) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (en_q[i] && (cmp_q[i] == count_q)) begin
          pend_d[i]  = 1'b1;
          fired_d[i] = 1'b1;
          if (rep_q[i]) begin
            cmp_d[i] = COUNT_WIDTH'(32'(count_q) + per_q[i]) & max_q;
          end
        end
      end
    end

    if (cmd_i.sum) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (sel[i]) per_d[i] = prod_q;
      end
    end

    if (cmd_i.arm) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (sel[i]) begin
          pend_d[i]  = arm_late;
          fired_d[i] = arm_late;
          en_d[i]    = 1'b1;
          cmp_d[i]   = arm_t;
        end
      end
    end

    if (cmd_i.misc) begin
      case (op_q)
        OP_DISABLE: en_d   = en_q & ~sel;
        OP_CLEAR:   pend_d = pend_q & ~clr_ext[NUM_CHANNELS-1:0];
        OP_REPEAT:  rep_d  = rep_on_q ? (rep_q | sel) : (rep_q & ~sel);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= WRAP_RST[COUNT_WIDTH-1:0];
      ten_q   <= 1'b0;
      lint_q  <= LARGEST_RST;
      tpm_q   <= TPM_RST;
      count_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cmp_q[i] <= '0;
        per_q[i] <= '0;
      end
      en_q    <= '0;
      pend_q  <= '0;
      rep_q   <= '0;
      fired_q <= '0;
    end else begin
      max_q   <= max_d;
      ten_q   <= ten_d;
      lint_q  <= lint_d;
      tpm_q   <= tpm_d;
      count_q <= count_d;
      cmp_q   <= cmp_d;
      per_q   <= per_d;
      en_q    <= en_d;
      pend_q  <= pend_d;
      rep_q   <= rep_d;
      fired_q <= fired_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= op_e'(in_op_i);
      ch_q     <= in_ch_i;
      val_q    <= in_value_i;
      clr_q    <= in_clr_i;
      rep_on_q <= in_rep_i;
      target_q <= in_value_i;
    end else if (cmd_i.sum) begin
      target_q <= 32'(count_q) + prod_q;
    end
    if (cmd_i.mul) begin
      prod_q <= val_q * 32'(tpm_q);
    end
    if (cmd_i.load_out) begin
      counter_value_o <= 32'(count_q);
      pending_bits_o  <= pend_ext[MASK_W-1:0];
      fired_bits_o    <= fired_ext[MASK_W-1:0];
      irq_o           <= |(pend_q & en_q);
    end
  end

  assign status_o.timer_en = ten_q;

endmodule

`default_nettype wire

>>> hdl/multi_channel_compare_timer.sv
// Requests are handled one at a time: the shared FSM walks each request through
//   count/compare (tick), multiply/add/arm (delay arm), arm alone (absolute arm) or a
//   single update step (disable/clear/repeat); an idle tick or unknown code goes
//   straight to the result.
// Reset (rst_ni, async, active low): counter, channel state and flags to zero,
//   wrap value all ones, timer off, late-fire interval 0xFFFF, ticks per ms 500.
`default_nettype none

module multi_channel_compare_timer import mct_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,  // 1..16
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF    // 8..32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  mct_in_if.sink                in_ch,
  mct_out_if.source             out_ch
);

  mct_cmd_t    cmd;
  mct_status_t status;

  // Controller: one-hot FSM. A request is taken only in IDLE; the output
  // register lets the next request in while the previous result waits.
  mct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_op_i     (in_ch.operation),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, counter, per-channel compare/period lanes,
  // the ms multiplier (registered before the add) and the result register.
  // Tick (timer on): count step, then all lanes compare to the new count in parallel.
  // Delay arm: multiply, add to count, then arm (masked target, late check).
  mct_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_op_i         (in_ch.operation),
    .in_ch_i         (in_ch.channel),
    .in_value_i      (in_ch.value),
    .in_clr_i        (in_ch.clear_mask),
    .in_rep_i        (in_ch.repeat_on),
    .cmd_i           (cmd),
    .status_o        (status),
    .counter_value_o (out_ch.counter_value),
    .pending_bits_o  (out_ch.pending_bits),
    .fired_bits_o    (out_ch.fired_bits),
    .irq_o           (out_ch.irq)
  );

  // a fired channel always leaves its pending bit set
  a_fired_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> ((out_ch.fired_bits & ~out_ch.pending_bits) == '0))
    else $error("fired bit without pending bit");

  // one request at a time: the controller leaves IDLE right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while busy");

  // no interrupt without a pending bit when all channels are visible
  a_irq_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.pending_bits == '0) && (NUM_CHANNELS <= MASK_W))
      |-> !out_ch.irq)
    else $error("irq with no pending channel");

endmodule

`default_nettype wire
